// ===== src/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and constants shared by the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int unsigned CP_WIDTH   = 21;
   localparam int unsigned BYTE_WIDTH = 8;

   // replacement character
   localparam logic [CP_WIDTH-1:0] REPL_CP = 21'h00FFFD;

   // sequence lengths
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   // byte class masks and patterns
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] CONT_BITS  = 8'h3F;
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  end_of_text;
   } req_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                malformed;
      logic                run_last;
   } rsp_type;

endpackage

// ===== src/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Lenient UTF-8 decoder: one byte in per item, zero to four code points out.
//
//   channel | ports                        | payload
//   --------+------------------------------+-------------------------------
//   request | req_valid, req_stall, req_data   | data_byte, end_of_text
//   result  | rsp_valid, rsp_stall, rsp_data   | code_point, malformed, run_last
//
// One byte is taken per cycle while no results are pending; its results are
// registered and shown from the next cycle on, one per cycle while rsp_stall
// is low. A byte with results holds the request side while the result
// register drains (the next byte is taken in the cycle the last result
// leaves). Bytes that only open or extend a sequence give nothing. Reset
// (synchronous) closes any open sequence and drops pending results.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  u8sd_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output u8sd_pkg::rsp_type  rsp_data
);

   // decoder state
   logic [2:0]                     needed_ff, needed_in;
   logic [1:0]                     held_ff, held_in;
   logic [u8sd_pkg::CP_WIDTH-1:0]  part_ff, part_in;

   // pending result bundle: leading replacements, main result, trailing ones
   logic [1:0]                     pre_ff, pre_in;
   logic                           prim_ff, prim_in;
   logic [u8sd_pkg::CP_WIDTH-1:0]  prim_cp_ff, prim_cp_in;
   logic                           prim_bad_ff, prim_bad_in;
   logic [1:0]                     post_ff, post_in;

   logic [2:0] left;
   logic       req_accept, rsp_accept;

   // decode signals
   logic [7:0]                    b;
   logic                          is_cont, seq_open, seq_done;
   logic [u8sd_pkg::CP_WIDTH-1:0] grown;
   logic [2:0]                    held_next;
   logic [2:0]                    need_a;
   logic [1:0]                    held_a;
   logic [1:0]                    pre_a;
   logic                          prim_a, prim_bad_a;
   logic [u8sd_pkg::CP_WIDTH-1:0] prim_cp_a, part_a;

   // results still to deliver
   assign left = {1'b0, pre_ff} + {2'b00, prim_ff} + {1'b0, post_ff};

   assign rsp_valid  = (left != 3'd0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = rsp_valid && !(rsp_accept && (left == 3'd1));
   assign req_accept = req_valid && !req_stall;

   // result select: leading replacements, then main, then trailing
   always_comb begin
      rsp_data.run_last = (left == 3'd1);
      if (pre_ff != 2'd0) begin
         rsp_data.code_point = u8sd_pkg::REPL_CP;
         rsp_data.malformed  = 1'b1;
      end else if (prim_ff) begin
         rsp_data.code_point = prim_cp_ff;
         rsp_data.malformed  = prim_bad_ff;
      end else begin
         rsp_data.code_point = u8sd_pkg::REPL_CP;
         rsp_data.malformed  = 1'b1;
      end
   end

   // byte decode
   always_comb begin
      b         = req_data.data_byte;
      is_cont   = ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE);
      seq_open  = (needed_ff != u8sd_pkg::LEN_NONE);
      grown     = {part_ff[u8sd_pkg::CP_WIDTH-7:0], b[5:0] & u8sd_pkg::CONT_BITS[5:0]};
      held_next = {1'b0, held_ff} + 3'd1;
      seq_done  = seq_open && is_cont;

      need_a     = needed_ff;
      held_a     = held_ff;
      part_a     = part_ff;
      pre_a      = 2'd0;
      prim_a     = 1'b0;
      prim_cp_a  = u8sd_pkg::REPL_CP;
      prim_bad_a = 1'b0;

      // continuation or break of an open sequence
      if (seq_open) begin
         if (is_cont) begin
            if (held_next >= needed_ff) begin
               prim_a    = 1'b1;
               prim_cp_a = grown;
               need_a    = u8sd_pkg::LEN_NONE;
               held_a    = 2'd0;
               part_a    = '0;
            end else begin
               held_a = held_next[1:0];
               part_a = grown;
            end
         end else begin
            pre_a  = held_ff;
            need_a = u8sd_pkg::LEN_NONE;
            held_a = 2'd0;
            part_a = '0;
         end
      end

      // fresh lead byte
      if (!seq_done) begin
         if (b[7] == 1'b0) begin
            prim_a    = 1'b1;
            prim_cp_a = {{(u8sd_pkg::CP_WIDTH-8){1'b0}}, b};
         end else if ((b & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE) begin
            need_a = u8sd_pkg::LEN_TWO;
            held_a = 2'd1;
            part_a = {{(u8sd_pkg::CP_WIDTH-8){1'b0}}, b & u8sd_pkg::LEAD2_BITS};
         end else if ((b & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE) begin
            need_a = u8sd_pkg::LEN_THREE;
            held_a = 2'd1;
            part_a = {{(u8sd_pkg::CP_WIDTH-8){1'b0}}, b & u8sd_pkg::LEAD3_BITS};
         end else if ((b & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE) begin
            need_a = u8sd_pkg::LEN_FOUR;
            held_a = 2'd1;
            part_a = {{(u8sd_pkg::CP_WIDTH-8){1'b0}}, b & u8sd_pkg::LEAD4_BITS};
         end else begin
            prim_a     = 1'b1;
            prim_cp_a  = u8sd_pkg::REPL_CP;
            prim_bad_a = 1'b1;
         end
      end

      // end of text flushes whatever is still open
      post_in = 2'd0;
      if (req_data.end_of_text && (need_a != u8sd_pkg::LEN_NONE)) begin
         post_in = held_a;
         need_a  = u8sd_pkg::LEN_NONE;
         held_a  = 2'd0;
         part_a  = '0;
      end
   end

   // next state: load on accept, else drain one result per accepted output
   always_comb begin
      needed_in   = needed_ff;
      held_in     = held_ff;
      part_in     = part_ff;
      pre_in      = pre_ff;
      prim_in     = prim_ff;
      prim_cp_in  = prim_cp_ff;
      prim_bad_in = prim_bad_ff;
      if (req_accept) begin
         needed_in   = need_a;
         held_in     = held_a;
         part_in     = part_a;
         pre_in      = pre_a;
         prim_in     = prim_a;
         prim_cp_in  = prim_cp_a;
         prim_bad_in = prim_bad_a;
      end else if (rsp_accept) begin
         if (pre_ff != 2'd0) begin
            pre_in = pre_ff - 2'd1;
         end else if (prim_ff) begin
            prim_in = 1'b0;
         end
      end
   end

   // trailing count kept apart: post_in from decode is loaded only on accept
   logic [1:0] post_next;
   always_comb begin
      post_next = post_ff;
      if (req_accept) begin
         post_next = post_in;
      end else if (rsp_accept && (pre_ff == 2'd0) && !prim_ff) begin
         post_next = post_ff - 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff <= u8sd_pkg::LEN_NONE;
         held_ff   <= 2'd0;
         pre_ff    <= 2'd0;
         prim_ff   <= 1'b0;
         post_ff   <= 2'd0;
      end else begin
         needed_ff <= needed_in;
         held_ff   <= held_in;
         pre_ff    <= pre_in;
         prim_ff   <= prim_in;
         post_ff   <= post_next;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      part_ff     <= part_in;
      prim_cp_ff  <= prim_cp_in;
      prim_bad_ff <= prim_bad_in;
   end

`ifndef SYNTHESIS
   // a new byte only enters as the last pending result leaves
   a_accept_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_valid) |-> (rsp_accept && rsp_data.run_last))
      else $error("byte accepted while results still pending");

   // an open sequence holds at least one byte and fewer than its length
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (needed_ff != u8sd_pkg::LEN_NONE) |->
         ((held_ff != 2'd0) && ({1'b0, held_ff} < needed_ff)))
      else $error("held count out of range for open sequence");

   // no held bytes without an open sequence
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (needed_ff == u8sd_pkg::LEN_NONE) |-> (held_ff == 2'd0))
      else $error("bytes held with no sequence open");

   // replacements always carry U+FFFD
   a_repl_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.malformed) |-> (rsp_data.code_point == u8sd_pkg::REPL_CP))
      else $error("malformed result without replacement value");

   // a run that is not finished carries on in the next cycle
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !rsp_data.run_last) |=> rsp_valid)
      else $error("result run ended early");
`endif

endmodule

// ===== sim/utf8_stream_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb
// Self-checking bench for the lenient UTF-8 stream decoder. Bytes are fed
// one item at a time. A behavioural decoder in the bench works out the code
// points each accepted byte should produce, and every result item leaving the
// block is checked against the oldest one still outstanding. Directed text
// covers the byte classes and the malformed cases. Random text, mostly
// well-formed sequences with broken sequences and noise mixed in, follows
// under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 5;
   localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_PER_BYTE = 4;
   localparam int EOT_PCT      = 8;

   typedef enum int { TEXT_GOOD, TEXT_BROKEN, TEXT_NOISE } text_kind_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   u8sd_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   u8sd_pkg::rsp_type rsp_data;

   // decoder state as the bench sees it
   logic [2:0]                    seq_len;
   logic [1:0]                    seq_held;
   logic [u8sd_pkg::CP_WIDTH-1:0] seq_value;

   u8sd_pkg::rsp_type byte_results[$];         // results of the byte being decoded
   u8sd_pkg::rsp_type pending_code_points[$];  // results still owed by the block

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int error_count   = 0;
   int bytes_sent    = 0;
   int eot_sent      = 0;
   int cps_checked   = 0;
   int repl_checked  = 0;
   int quiet_cycles  = 0;

   utf8_stream_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // behavioural decoder
   // ---------------------------------------------------------------------
   function automatic void add_result(input logic [u8sd_pkg::CP_WIDTH-1:0] cp,
                                      input logic bad);
      u8sd_pkg::rsp_type r;
      r.code_point = cp;
      r.malformed  = bad;
      r.run_last   = 1'b0;
      if (byte_results.size() < MAX_PER_BYTE)
         byte_results = {byte_results, r};
   endfunction

   function automatic void close_sequence();
      seq_len   = u8sd_pkg::LEN_NONE;
      seq_held  = '0;
      seq_value = '0;
   endfunction

   // one replacement per byte held, then no sequence open
   function automatic void flush_sequence();
      for (int i = 0; i < seq_held; i++)
         add_result(u8sd_pkg::REPL_CP, 1'b1);
      close_sequence();
   endfunction

   function automatic void open_sequence(input logic [2:0] len, input logic [7:0] bits);
      seq_len   = len;
      seq_held  = 2'd1;
      seq_value = {{(u8sd_pkg::CP_WIDTH-8){1'b0}}, bits};
   endfunction

   function automatic void decode_byte(input u8sd_pkg::req_type item);
      logic [7:0] b;
      bit         taken;
      b     = item.data_byte;
      taken = 1'b0;
      byte_results.delete();

      // continue or break an open sequence
      if (seq_len != u8sd_pkg::LEN_NONE) begin
         if ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE) begin
            seq_value = {seq_value[u8sd_pkg::CP_WIDTH-7:0], b[5:0]};
            if (seq_held + 1 >= seq_len) begin
               add_result(seq_value, 1'b0);
               close_sequence();
            end else begin
               seq_held = seq_held + 2'd1;
            end
            taken = 1'b1;
         end else begin
            flush_sequence();
         end
      end

      // byte read as a lead
      if (!taken) begin
         if (b < u8sd_pkg::CONT_CODE)
            add_result({{(u8sd_pkg::CP_WIDTH-8){1'b0}}, b}, 1'b0);
         else if ((b & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE)
            open_sequence(u8sd_pkg::LEN_TWO, b & u8sd_pkg::LEAD2_BITS);
         else if ((b & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE)
            open_sequence(u8sd_pkg::LEN_THREE, b & u8sd_pkg::LEAD3_BITS);
         else if ((b & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE)
            open_sequence(u8sd_pkg::LEN_FOUR, b & u8sd_pkg::LEAD4_BITS);
         else
            add_result(u8sd_pkg::REPL_CP, 1'b1);
      end

      if (item.end_of_text && seq_len != u8sd_pkg::LEN_NONE)
         flush_sequence();

      if (byte_results.size() > 0)
         byte_results[byte_results.size()-1].run_last = 1'b1;
      pending_code_points = {pending_code_points, byte_results};
   endfunction

   // ---------------------------------------------------------------------
   // reporting and checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      error_count++;
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // compare each accepted result with the oldest one owed
   always @(posedge clock) begin
      u8sd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_code_points.size() == 0) begin
            report_mismatch($sformatf("unexpected result cp=%06h bad=%b last=%b",
               rsp_data.code_point, rsp_data.malformed, rsp_data.run_last));
         end else begin
            want = pending_code_points.pop_front();
            if (rsp_data.code_point !== want.code_point)
               report_mismatch($sformatf("code_point %06h, want %06h",
                  rsp_data.code_point, want.code_point));
            if (rsp_data.malformed !== want.malformed)
               report_mismatch($sformatf("malformed %b, want %b (cp %06h)",
                  rsp_data.malformed, want.malformed, want.code_point));
            if (rsp_data.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %b, want %b (cp %06h)",
                  rsp_data.run_last, want.run_last, want.code_point));
            if (want.malformed)
               repl_checked++;
         end
         cps_checked++;
      end
   end

   // watchdog: give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] timeout: no item moved for %0d cycles, %0d results owed",
            $realtime, STALL_LIMIT, pending_code_points.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic eot);
      u8sd_pkg::req_type item;
      item.data_byte   = b;
      item.end_of_text = eot;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      decode_byte(item);
      bytes_sent++;
      if (eot)
         eot_sent++;
   endtask

   task automatic send_text(input logic [7:0] text[$], input bit eot_at_end);
      foreach (text[i])
         send_byte(text[i], eot_at_end && (i == text.size() - 1));
   endtask

   // hold the sender off until the block owes nothing
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_code_points.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_ascii();
      send_text('{8'h00, 8'h7F}, 1'b1);
   endtask

   task automatic test_sequences();
      send_text('{8'hC2, 8'hA9}, 1'b0);               // two bytes
      send_text('{8'hE2, 8'h82, 8'hAC}, 1'b0);        // three bytes
      send_text('{8'hEF, 8'hBF, 8'hBD}, 1'b0);        // real U+FFFD, not malformed
      send_text('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b0); // largest 21-bit value
   endtask

   task automatic test_malformed();
      send_text('{8'h80}, 1'b0);                      // stray continuation
      send_text('{8'hFF}, 1'b0);                      // invalid lead
      send_text('{8'hE2, 8'h82, 8'h41}, 1'b0);        // broken by ASCII
      // three held, new lead at end of text: 3 + 1 replacements
      send_text('{8'hF0, 8'h9F, 8'h98, 8'hF0}, 1'b1);
      send_text('{8'hC3}, 1'b1);                      // cut short by end of text
   endtask

   function automatic logic [7:0] random_lead(input int len);
      case (len)
         1:       return 8'($urandom_range(0, 127));
         2:       return u8sd_pkg::LEAD2_CODE | 8'($urandom_range(0, 31));
         3:       return u8sd_pkg::LEAD3_CODE | 8'($urandom_range(0, 15));
         default: return u8sd_pkg::LEAD4_CODE | 8'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic run_random_text(input int s_idle, input int r_idle, input int n_bytes);
      logic [7:0]    text[$];
      text_kind_type kind;
      int            len;
      int            sent;
      int            pick;
      logic [7:0]    b;
      send_idle_pct = s_idle;
      rsp_idle_pct  = r_idle;
      sent = 0;
      while (sent < n_bytes) begin
         text.delete();
         pick = $urandom_range(0, 99);
         kind = (pick < 65) ? TEXT_GOOD : (pick < 85) ? TEXT_BROKEN : TEXT_NOISE;
         len  = $urandom_range(1, 4);
         case (kind)
            TEXT_GOOD: begin
               text = {text, random_lead(len)};
               for (int i = 1; i < len; i++)
                  text = {text, u8sd_pkg::CONT_CODE | 8'($urandom_range(0, 63))};
            end
            TEXT_BROKEN: begin
               len = $urandom_range(2, 4);
               text = {text, random_lead(len)};
               for (int i = $urandom_range(0, len - 2); i > 0; i--)
                  text = {text, u8sd_pkg::CONT_CODE | 8'($urandom_range(0, 63))};
               b = 8'($urandom_range(0, 255));
               if ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE)
                  b = b ^ 8'h40;
               text = {text, b};
            end
            default: begin
               text = {text, 8'($urandom_range(0, 255))};
            end
         endcase
         foreach (text[i])
            send_byte(text[i], $urandom_range(0, 99) < EOT_PCT);
         sent += text.size();
      end
   endtask

   task automatic test_random_traffic();
      run_random_text(7, 47, 29);
      wait_drained();
      run_random_text(47, 7, 29);
      wait_drained();
      run_random_text(0, 0, 29);
   endtask

   // ---------------------------------------------------------------------
   // sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      close_sequence();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 7;
      rsp_idle_pct  = 47;
      test_ascii();
      test_sequences();
      test_malformed();
      wait_drained();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_code_points.size() != 0)
         report_mismatch($sformatf("%0d results never arrived",
            pending_code_points.size()));

      $display("run covered %0d bytes (%0d flagged end of text) and checked %0d results,",
         bytes_sent, eot_sent, cps_checked);
      $display("of which %0d were replacements, under three idling patterns",
         repl_checked);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
